/* rtl/core/cdm_pkg.sv */
// ----------------------------------------------------------------------------
// cdm_pkg
// Shared widths, types, register indexes and the 2^-x gain table of the
// clip distortion / dry-wet mix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cdm_pkg;

	// Sample format: signed Q1.(SAMPLE_WIDTH-1)
	localparam int SAMPLE_WIDTH = 24;
	localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
	// Fraction bits below the 4-bit table index
	localparam int LOW_BITS     = FRAC_BITS - 4;
	// Gain is unsigned Q1.16
	localparam int GAIN_WIDTH   = 17;
	localparam int GAIN_FRAC    = 16;
	localparam int PCT_WIDTH    = 7;
	// Magnitude of the weighted sum, before the divide by 100
	localparam int MIX_WIDTH    = SAMPLE_WIDTH + PCT_WIDTH;
	// Divide by 100 as multiply by a rounded-up reciprocal
	localparam int DIV_SHIFT    = MIX_WIDTH + PCT_WIDTH;
	localparam int DIV_WIDTH    = MIX_WIDTH + 1;
	localparam int NUM_STAGES   = 10;

	localparam logic [63:0] DIV_MUL_FULL = ((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100;
	localparam logic [DIV_WIDTH-1:0] DIV_MUL = DIV_MUL_FULL[DIV_WIDTH-1:0];

	localparam logic [PCT_WIDTH-1:0] PCT_FULL = PCT_WIDTH'(100);
	localparam logic [MIX_WIDTH-1:0] MIX_HALF = MIX_WIDTH'(50);

	// Configuration port
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = FRAC_BITS;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HARD_MODE   = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLIP_LEVEL  = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WET_PERCENT = 2'd2;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [SAMPLE_WIDTH-1:0]        mag_t;
	typedef logic [FRAC_BITS-1:0]           level_t;
	typedef logic [GAIN_WIDTH-1:0]          gain_t;
	typedef logic [PCT_WIDTH-1:0]           pct_t;
	typedef logic [NUM_STAGES-1:0]          stage_en_t;

	localparam level_t CLIP_LEVEL_RESET  = level_t'(1) << (FRAC_BITS - 1);
	localparam pct_t   WET_PERCENT_RESET = PCT_FULL;

	// Live settings seen by the datapath (wet share already saturated)
	typedef struct packed {
		logic   hard_mode;
		level_t clip_level;
		pct_t   wet_pct;
	} cfg_t;

	// round(65536 * 2^(-k/16)), k = 0..16
	function automatic gain_t exp2_tab(input logic [4:0] idx);
		gain_t val;
		case (idx)
			5'd0:    val = 17'd65536;
			5'd1:    val = 17'd62757;
			5'd2:    val = 17'd60097;
			5'd3:    val = 17'd57549;
			5'd4:    val = 17'd55109;
			5'd5:    val = 17'd52773;
			5'd6:    val = 17'd50535;
			5'd7:    val = 17'd48393;
			5'd8:    val = 17'd46341;
			5'd9:    val = 17'd44376;
			5'd10:   val = 17'd42495;
			5'd11:   val = 17'd40693;
			5'd12:   val = 17'd38968;
			5'd13:   val = 17'd37316;
			5'd14:   val = 17'd35734;
			5'd15:   val = 17'd34219;
			5'd16:   val = 17'd32768;
			default: val = 17'd32768;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/cdm_stream_if.sv */
// ----------------------------------------------------------------------------
// cdm_stream_if
// Valid/ready stream channels for input and output samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdm_in_if;
	import cdm_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface cdm_out_if;
	import cdm_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/clip_distortion_dry_wet_mix_top.sv */
// ----------------------------------------------------------------------------
// clip_distortion_dry_wet_mix_top
// Hard/soft sample clipper with dry/wet mix, ten-stage pipeline.
//
//   channel  | dir | payload            | handshake
//   ---------+-----+--------------------+-----------------------------
//   in_ch    | in  | sample_in  [23:0]  | valid/ready, one sample
//   out_ch   | out | sample_out [23:0]  | valid/ready, one sample
//   cfg      | in  | cfg_data   [22:0]  | cfg_we + cfg_index, no ready
//
// One request per clock when the output is taken. The gain lookup,
// interpolation multiply, clip multiply and the reciprocal divide-by-100
// multiply each own one of the pipeline stages.
// Each stage advances when it is empty or the next one advances, so bubbles
// close up behind a stalled output and nothing is lost or repeated.
// Reset clears stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module clip_distortion_dry_wet_mix_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [cdm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  wire logic [cdm_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
	cdm_in_if.sink                                      in_ch,
	cdm_out_if.source                                   out_ch
);
	import cdm_pkg::*;

	logic      hard_mode_q;
	level_t    clip_level_q;
	pct_t      wet_percent_q;
	cfg_t      cfg;

	stage_en_t ld;
	stage_en_t valid_q;

	logic      neg_s4, over_s4, neg_s6;
	mag_t      mag_s4, diff_s4, mag_s6, wmag_s6;
	gain_t     gain_s4;
	sample_t   sample_out_s10;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_mode_q   <= 1'b0;
			clip_level_q  <= CLIP_LEVEL_RESET;
			wet_percent_q <= WET_PERCENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HARD_MODE:   hard_mode_q   <= cfg_data[0];
				REG_CLIP_LEVEL:  clip_level_q  <= cfg_data[FRAC_BITS-1:0];
				REG_WET_PERCENT: wet_percent_q <= cfg_data[PCT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Wet share saturates at 100
	assign cfg.hard_mode  = hard_mode_q;
	assign cfg.clip_level = clip_level_q;
	assign cfg.wet_pct    = (wet_percent_q > PCT_FULL) ? PCT_FULL : wet_percent_q;

	// Stage load enables: a stage loads when empty or draining
	always_comb begin
		ld[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ch.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--)
			ld[k] = !valid_q[k] || ld[k+1];
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ld[0])
				valid_q[0] <= in_ch.valid;
			for (int k = 1; k < NUM_STAGES; k++)
				if (ld[k])
					valid_q[k] <= valid_q[k-1];
		end
	end

	assign in_ch.ready       = ld[0];
	assign out_ch.valid      = valid_q[NUM_STAGES-1];
	assign out_ch.sample_out = sample_out_s10;

	cdm_gain u_gain (
		.clk       (clk),
		.ld        (ld),
		.cfg       (cfg),
		.sample_in (in_ch.sample_in),
		.neg_s4    (neg_s4),
		.mag_s4    (mag_s4),
		.over_s4   (over_s4),
		.diff_s4   (diff_s4),
		.gain_s4   (gain_s4)
	);

	cdm_clip u_clip (
		.clk     (clk),
		.ld      (ld),
		.cfg     (cfg),
		.neg_s4  (neg_s4),
		.mag_s4  (mag_s4),
		.over_s4 (over_s4),
		.diff_s4 (diff_s4),
		.gain_s4 (gain_s4),
		.neg_s6  (neg_s6),
		.mag_s6  (mag_s6),
		.wmag_s6 (wmag_s6)
	);

	cdm_mix u_mix (
		.clk            (clk),
		.ld             (ld),
		.cfg            (cfg),
		.neg_s6         (neg_s6),
		.mag_s6         (mag_s6),
		.wmag_s6        (wmag_s6),
		.sample_out_s10 (sample_out_s10)
	);

endmodule

`default_nettype wire

/* rtl/core/cdm_gain.sv */
// ----------------------------------------------------------------------------
// cdm_gain
// Stages 1-4: sample magnitude, threshold compare and the 2^-|x| gain
// (table lookup plus linear interpolation).
// ----------------------------------------------------------------------------
`default_nettype none

module cdm_gain (
	input  wire logic              clk,
	input  wire cdm_pkg::stage_en_t ld,
	input  wire cdm_pkg::cfg_t      cfg,
	input  wire cdm_pkg::sample_t   sample_in,
	output logic                   neg_s4,
	output cdm_pkg::mag_t          mag_s4,
	output logic                   over_s4,
	output cdm_pkg::mag_t          diff_s4,
	output cdm_pkg::gain_t         gain_s4
);
	import cdm_pkg::*;

	mag_t                t_ext;
	mag_t                raw;
	mag_t                mag_c;

	logic                neg_s1, over_s1, ip_s1;
	mag_t                mag_s1, diff_s1;
	logic [3:0]          idx_s1;
	logic [LOW_BITS-1:0] rem_s1;

	logic                neg_s2, over_s2, ip_s2;
	mag_t                mag_s2, diff_s2;
	logic [LOW_BITS-1:0] rem_s2;
	gain_t               hi_s2, delta_s2;

	logic                neg_s3, over_s3, ip_s3;
	mag_t                mag_s3, diff_s3;
	gain_t               hi_s3;
	logic [GAIN_WIDTH+LOW_BITS-1:0] prod_s3;

	gain_t               step_c;
	gain_t               lo_c, hi_c;

	// Magnitude: the most negative sample maps to 2^FRAC_BITS
	assign t_ext = {1'b0, cfg.clip_level};
	assign raw   = mag_t'(sample_in);
	assign mag_c = sample_in[SAMPLE_WIDTH-1] ? (~raw + mag_t'(1)) : raw;

	// Stage 1: magnitude, compare, split into table index and remainder
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			neg_s1  <= sample_in[SAMPLE_WIDTH-1];
			mag_s1  <= mag_c;
			over_s1 <= (mag_c > t_ext);
			diff_s1 <= mag_c - t_ext;
			ip_s1   <= mag_c[FRAC_BITS];
			idx_s1  <= mag_c[FRAC_BITS-1 -: 4];
			rem_s1  <= mag_c[LOW_BITS-1:0];
		end
	end

	// Stage 2: table lookup of both neighbors
	assign hi_c = exp2_tab({1'b0, idx_s1});
	assign lo_c = exp2_tab({1'b0, idx_s1} + 5'd1);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			neg_s2   <= neg_s1;
			mag_s2   <= mag_s1;
			over_s2  <= over_s1;
			diff_s2  <= diff_s1;
			ip_s2    <= ip_s1;
			rem_s2   <= rem_s1;
			hi_s2    <= hi_c;
			delta_s2 <= hi_c - lo_c;
		end
	end

	// Stage 3: interpolation product
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
			over_s3 <= over_s2;
			diff_s3 <= diff_s2;
			ip_s3   <= ip_s2;
			hi_s3   <= hi_s2;
			prod_s3 <= {{LOW_BITS{1'b0}}, delta_s2} * {{GAIN_WIDTH{1'b0}}, rem_s2};
		end
	end

	// Stage 4: truncated interpolation, halve when the integer bit is set
	assign step_c = prod_s3[GAIN_WIDTH+LOW_BITS-1:LOW_BITS];

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			neg_s4  <= neg_s3;
			mag_s4  <= mag_s3;
			over_s4 <= over_s3;
			diff_s4 <= diff_s3;
			gain_s4 <= (hi_s3 - step_c) >> ip_s3;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/cdm_clip.sv */
// ----------------------------------------------------------------------------
// cdm_clip
// Stages 5-6: soft clip product, rounding, and hard/soft/pass selection of
// the wet magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module cdm_clip (
	input  wire logic               clk,
	input  wire cdm_pkg::stage_en_t ld,
	input  wire cdm_pkg::cfg_t      cfg,
	input  wire logic               neg_s4,
	input  wire cdm_pkg::mag_t      mag_s4,
	input  wire logic               over_s4,
	input  wire cdm_pkg::mag_t      diff_s4,
	input  wire cdm_pkg::gain_t     gain_s4,
	output logic                    neg_s6,
	output cdm_pkg::mag_t           mag_s6,
	output cdm_pkg::mag_t           wmag_s6
);
	import cdm_pkg::*;

	localparam int PW = SAMPLE_WIDTH + GAIN_WIDTH;
	localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (GAIN_FRAC - 1);

	logic          neg_s5, over_s5;
	mag_t          mag_s5;
	logic [PW-1:0] prod_s5;

	mag_t          t_ext;
	logic [PW-1:0] rnd_c;
	mag_t          soft_c;
	mag_t          wmag_c;

	// Stage 5: (|x| - t) * gain
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			neg_s5  <= neg_s4;
			mag_s5  <= mag_s4;
			over_s5 <= over_s4;
			prod_s5 <= {{GAIN_WIDTH{1'b0}}, diff_s4} * {{SAMPLE_WIDTH{1'b0}}, gain_s4};
		end
	end

	// Stage 6: round, add threshold back, pick the wet magnitude
	assign t_ext  = {1'b0, cfg.clip_level};
	assign rnd_c  = (prod_s5 + ROUND_HALF) >> GAIN_FRAC;
	assign soft_c = rnd_c[SAMPLE_WIDTH-1:0] + t_ext;

	always_comb begin
		if (!over_s5)
			wmag_c = mag_s5;
		else if (cfg.hard_mode)
			wmag_c = t_ext;
		else
			wmag_c = soft_c;
	end

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			neg_s6  <= neg_s5;
			mag_s6  <= mag_s5;
			wmag_s6 <= wmag_c;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/cdm_mix.sv */
// ----------------------------------------------------------------------------
// cdm_mix
// Stages 7-10: dry/wet weighting, rounding offset, divide by 100 through a
// reciprocal multiply, and sign restore. Wet and dry share the sign of the
// input, so the sum is formed on magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module cdm_mix (
	input  wire logic               clk,
	input  wire cdm_pkg::stage_en_t ld,
	input  wire cdm_pkg::cfg_t      cfg,
	input  wire logic               neg_s6,
	input  wire cdm_pkg::mag_t      mag_s6,
	input  wire cdm_pkg::mag_t      wmag_s6,
	output cdm_pkg::sample_t        sample_out_s10
);
	import cdm_pkg::*;

	localparam int QW = MIX_WIDTH + DIV_WIDTH;

	logic                 neg_s7, neg_s8, neg_s9;
	logic [MIX_WIDTH-1:0] wprod_s7, dprod_s7;
	logic [MIX_WIDTH-1:0] num_s8;
	logic [QW-1:0]        quot_s9;
	pct_t                 dry_pct;
	mag_t                 res_c;

	assign dry_pct = PCT_FULL - cfg.wet_pct;

	// Stage 7: weight both paths
	always_ff @(posedge clk) begin
		if (ld[6]) begin
			neg_s7   <= neg_s6;
			wprod_s7 <= {{PCT_WIDTH{1'b0}}, wmag_s6} * {{SAMPLE_WIDTH{1'b0}}, cfg.wet_pct};
			dprod_s7 <= {{PCT_WIDTH{1'b0}}, mag_s6} * {{SAMPLE_WIDTH{1'b0}}, dry_pct};
		end
	end

	// Stage 8: sum plus half of the divisor (ties away from zero)
	always_ff @(posedge clk) begin
		if (ld[7]) begin
			neg_s8 <= neg_s7;
			num_s8 <= wprod_s7 + dprod_s7 + MIX_HALF;
		end
	end

	// Stage 9: reciprocal multiply
	always_ff @(posedge clk) begin
		if (ld[8]) begin
			neg_s9  <= neg_s8;
			quot_s9 <= {{DIV_WIDTH{1'b0}}, num_s8} * {{MIX_WIDTH{1'b0}}, DIV_MUL};
		end
	end

	// Stage 10: quotient, sign restore
	assign res_c = quot_s9[DIV_SHIFT +: SAMPLE_WIDTH];

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			sample_out_s10 <= neg_s9 ? sample_t'(~res_c + mag_t'(1)) : sample_t'(res_c);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/cdm_checker.sv */
// ----------------------------------------------------------------------------
// cdm_checker
// Port-level checks of the clip/mix pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cdm_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire cdm_pkg::sample_t       sample_out
);
	import cdm_pkg::*;

	// A taken output slot lets the whole pipe advance
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input not ready while output is being taken");

	// An empty output stage never blocks the input
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// Stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");

	// Stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out))
		else $error("output sample changed while stalled");

endmodule

bind clip_distortion_dry_wet_mix_top cdm_checker u_cdm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out)
);

`default_nettype wire
